// ----- rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the serial bus frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int PAYLOAD_BYTES = 22;
  localparam int NUM_CH        = 16;
  localparam int CH_W          = 11;
  localparam int CH_IDX_W      = $clog2(NUM_CH);
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;

  localparam logic [7:0]          START_BYTE   = 8'h0F;
  localparam logic [POS_W-1:0]    LAST_POS     = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0]    LAST_PAYLOAD = POS_W'(PAYLOAD_BYTES);
  localparam logic [CH_IDX_W-1:0] LAST_CH      = CH_IDX_W'(NUM_CH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_byte;   // shift a payload byte in at the top
    logic next_ch;     // drop the channel just delivered
  } dp_cmd_t;

endpackage

// ----- rtl/sbus_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// Latency: the first channel is shown the cycle after the 25th frame byte is taken.
// Throughput: one byte per cycle while collecting; each frame then gives a burst
// of 16 channels, one per cycle at best, set by the 11-bit shift-out of the payload.
// The input is stalled during the burst, so no new frame byte is taken until it ends.
// Reset (synchronous, active low) returns to hunting for the start byte.
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit
// Serial bus frame receiver: syncs on the start byte, collects a 25-byte
// frame and emits its sixteen 11-bit channel values in order.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_unit
  import sfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CH_IDX_W-1:0] out_channel_index,
  output logic [CH_W-1:0]     out_channel_value,
  output logic                out_last_channel
);

  dp_cmd_t cmd;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .rx_byte   (in_rx_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ch_index  (out_channel_index),
    .ch_last   (out_last_channel),
    .cmd       (cmd)
  );

  sfr_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .rx_byte  (in_rx_byte),
    .ch_value (out_channel_value)
  );

endmodule

// ----- rtl/sfr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_datapath
// Payload shift register: bytes 1..22 enter at the top, channels leave
// 11 bits at a time from the bottom.
// ----------------------------------------------------------------------------
module sfr_datapath
  import sfr_pkg::*;
(
  input  logic            clk,
  input  dp_cmd_t         cmd,
  input  logic [7:0]      rx_byte,
  output logic [CH_W-1:0] ch_value
);

  logic [PAYLOAD_W-1:0] payload_r;
  logic [PAYLOAD_W-1:0] payload_nxt;

  always_comb begin
    payload_nxt = payload_r;
    if (cmd.load_byte) begin
      payload_nxt = {rx_byte, payload_r[PAYLOAD_W-1:8]};
    end else if (cmd.next_ch) begin
      payload_nxt = payload_r >> CH_W;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

  // after 22 loads byte 1 sits in the low byte, so channel 0 is bits [10:0]
  assign ch_value = payload_r[CH_W-1:0];

endmodule

// ----- rtl/sfr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ctrl
// Frame sync, byte position and channel sequencing.
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          rx_byte,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CH_IDX_W-1:0] ch_index,
  output logic                ch_last,
  output dp_cmd_t             cmd
);

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CH_IDX_W-1:0] ch_r, ch_nxt;
  logic                in_acc;
  logic                out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    ch_nxt        = ch_r;
    in_stall      = 1'b0;
    out_valid     = 1'b0;
    cmd.load_byte = 1'b0;
    cmd.next_ch   = 1'b0;
    in_acc        = 1'b0;
    out_acc       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_acc = in_valid;
        if (in_acc && rx_byte == START_BYTE) begin
          pos_nxt   = POS_W'(1);
          state_nxt = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        in_acc = in_valid;
        if (in_acc) begin
          // flags and end byte are counted but not kept
          cmd.load_byte = (pos_r <= LAST_PAYLOAD);
          if (pos_r == LAST_POS) begin
            pos_nxt   = '0;
            ch_nxt    = '0;
            state_nxt = ST_EMIT;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_EMIT: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
        out_acc   = !out_stall;
        if (out_acc) begin
          cmd.next_ch = 1'b1;
          ch_nxt      = ch_r + CH_IDX_W'(1);
          if (ch_r == LAST_CH) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ch_index = ch_r;
  assign ch_last  = (ch_r == LAST_CH);

endmodule

// ----- rtl/sfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CH_IDX_W-1:0] out_channel_index,
  input logic [CH_W-1:0]     out_channel_value,
  input logic                out_last_channel
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel_index)
      && $stable(out_channel_value) && $stable(out_last_channel))
    else $error("stalled output item changed");

  // no bytes are taken during a burst
  a_stall_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input not stalled during channel burst");

  a_ch_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_channel |=> out_valid
      && out_channel_index == CH_IDX_W'($past(out_channel_index) + CH_IDX_W'(1)))
    else $error("channel burst broke sequence");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_channel == (out_channel_index == LAST_CH)))
    else $error("last flag does not match channel 15");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_channel |=> !out_valid)
    else $error("output continued past last channel");

endmodule

bind sbus_frame_receiver_unit sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_channel_index (out_channel_index),
  .out_channel_value (out_channel_value),
  .out_last_channel  (out_last_channel)
);
